### hdl/lobm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the order book matcher.
package lobm_pkg;

    // Book geometry
    localparam int ORDER_SLOTS  = 64;
    localparam int SLOT_W       = 6;
    localparam int PTR_W        = SLOT_W + 1;
    localparam int PRICE_LEVELS = 1024;
    localparam int LVL_W        = 10;
    localparam int LI_W         = LVL_W + 1;
    localparam int LI_DEPTH     = 2 * PRICE_LEVELS;
    localparam int CNT_W        = SLOT_W + 1;
    localparam int BEST_W       = LVL_W + 2;

    // Field widths
    localparam int ID_W  = 31;
    localparam int QTY_W = 16;

    // Stream packing
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 56;

    localparam logic [PTR_W-1:0]  NIL_PTR  = PTR_W'(ORDER_SLOTS);
    localparam logic [LI_W-1:0]   CLR_LAST = LI_W'(LI_DEPTH - 1);
    localparam logic [CNT_W-1:0]  POOL_FULL_CNT = CNT_W'(ORDER_SLOTS);
    localparam logic [SLOT_W-1:0] SCAN_LAST = SLOT_W'(ORDER_SLOTS - 1);
    localparam logic signed [BEST_W-1:0] BID_NONE = -BEST_W'(1);
    localparam logic signed [BEST_W-1:0] ASK_NONE = BEST_W'(PRICE_LEVELS);

    // Request kinds
    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_MODIFY = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Result status codes
    localparam logic [1:0] RES_OK        = 2'd0;
    localparam logic [1:0] RES_UNKNOWN   = 2'd1;
    localparam logic [1:0] RES_POOL_FULL = 2'd2;

    // Controller states
    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_ADD_START, ST_LVL_CHK, ST_HEAD_RD, ST_HEAD_CHK,
        ST_LVL_NEXT, ST_FILL, ST_EMIT_FILL, ST_FIX_BID, ST_FIX_BID_CHK, ST_FIX_ASK,
        ST_FIX_ASK_CHK, ST_REST_CHK, ST_REST_POP, ST_REST_WR, ST_REST_LINK, ST_FIND,
        ST_FIND_CHK, ST_UNL_RD, ST_UNL_CHK, ST_WALK_RD, ST_WALK_CHK, ST_RELEASE,
        ST_FIN_ZERO, ST_FIN_UNK, ST_FIN_FULL, ST_FIN_REST
    } state_t;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NOP, OP_CLEAR, OP_IDLE, OP_DECODE, OP_ADD_START, OP_HEAD_RD, OP_HEAD_CHK,
        OP_LVL_NEXT, OP_FILL, OP_EMIT_FILL, OP_FIX_BID, OP_FIX_BID_CHK, OP_FIX_ASK,
        OP_FIX_ASK_CHK, OP_REST_POP, OP_REST_WR, OP_REST_LINK, OP_FIND, OP_FIND_CHK,
        OP_UNL_RD, OP_UNL_CHK, OP_WALK_RD, OP_WALK_CHK, OP_RELEASE, OP_FIN_ZERO,
        OP_FIN_UNK, OP_FIN_FULL, OP_FIN_REST
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic    clr_done;
        logic    in_fire;
        action_t action;
        logic    rem_zero;
        logic    pool_empty;
        logic    lvl_go;
        logic    head_nil;
        logic    fill_done;
        logic    find_hit;
        logic    scan_last;
        logic    unl_hit;
        logic    walk_end;
        logic    bid_none;
        logic    ask_none;
        logic    out_free;
    } stat_t;

endpackage

### hdl/lobm_ctrl.sv
// Sequencer for the order book: walks each request through its steps and commands the datapath.
module lobm_ctrl import lobm_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   ctx_reg, ctx_next;   // 1: fix of best prices follows a match walk

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ctx_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        unique case (state_reg)
            ST_CLEAR:      if (stat.clr_done) state_next = ST_IDLE;
            ST_IDLE:       if (stat.in_fire) state_next = ST_DECODE;
            ST_DECODE: begin
                ctx_next = 1'b0;
                priority case (stat.action)
                    ACT_ADD:                state_next = ST_ADD_START;
                    ACT_CANCEL, ACT_MODIFY: state_next = ST_FIND;
                    default:                state_next = ST_FIN_ZERO;
                endcase
            end
            ST_ADD_START: begin
                ctx_next = 1'b1;
                priority if (stat.rem_zero) state_next = ST_FIN_ZERO;
                else if (stat.pool_empty)   state_next = ST_FIN_FULL;
                else                        state_next = ST_LVL_CHK;
            end
            ST_LVL_CHK:    state_next = stat.lvl_go ? ST_HEAD_RD : ST_FIX_BID;
            ST_HEAD_RD:    state_next = ST_HEAD_CHK;
            ST_HEAD_CHK:   state_next = (stat.head_nil || stat.rem_zero) ? ST_LVL_NEXT : ST_FILL;
            ST_LVL_NEXT:   state_next = ST_LVL_CHK;
            ST_FILL:       state_next = stat.fill_done ? ST_EMIT_FILL : ST_HEAD_CHK;
            ST_EMIT_FILL:  if (stat.out_free) state_next = ST_HEAD_CHK;
            ST_FIX_BID:    state_next = stat.bid_none ? ST_FIX_ASK : ST_FIX_BID_CHK;
            ST_FIX_BID_CHK: state_next = stat.head_nil ? ST_FIX_BID : ST_FIX_ASK;
            ST_FIX_ASK, ST_FIX_ASK_CHK: begin
                if ((state_reg == ST_FIX_ASK && !stat.ask_none)) begin
                    state_next = ST_FIX_ASK_CHK;
                end else if (state_reg == ST_FIX_ASK_CHK && stat.head_nil) begin
                    state_next = ST_FIX_ASK;
                end else if (ctx_reg) begin
                    state_next = ST_REST_CHK;
                end else if (stat.action == ACT_CANCEL) begin
                    state_next = ST_FIN_ZERO;
                end else begin
                    state_next = ST_ADD_START;
                end
            end
            ST_REST_CHK:   state_next = stat.rem_zero ? ST_FIN_ZERO : ST_REST_POP;
            ST_REST_POP:   state_next = ST_REST_WR;
            ST_REST_WR:    state_next = ST_REST_LINK;
            ST_REST_LINK:  state_next = ST_FIN_REST;
            ST_FIND:       state_next = ST_FIND_CHK;
            ST_FIND_CHK: begin
                priority if (stat.find_hit) state_next = ST_UNL_RD;
                else if (stat.scan_last)    state_next = ST_FIN_UNK;
                else                        state_next = ST_FIND;
            end
            ST_UNL_RD:     state_next = ST_UNL_CHK;
            ST_UNL_CHK:    state_next = stat.unl_hit ? ST_RELEASE : ST_WALK_RD;
            ST_WALK_RD:    state_next = ST_WALK_CHK;
            ST_WALK_CHK:   state_next = stat.walk_end ? ST_RELEASE : ST_WALK_RD;
            ST_RELEASE:    state_next = ST_FIX_BID;
            ST_FIN_ZERO, ST_FIN_UNK, ST_FIN_FULL, ST_FIN_REST: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default:       state_next = ST_CLEAR;
        endcase
    end

    // Command decode
    always_comb begin
        unique case (state_reg)
            ST_CLEAR:       cmd.op = OP_CLEAR;
            ST_IDLE:        cmd.op = OP_IDLE;
            ST_DECODE:      cmd.op = OP_DECODE;
            ST_ADD_START:   cmd.op = OP_ADD_START;
            ST_HEAD_RD:     cmd.op = OP_HEAD_RD;
            ST_HEAD_CHK:    cmd.op = OP_HEAD_CHK;
            ST_LVL_NEXT:    cmd.op = OP_LVL_NEXT;
            ST_FILL:        cmd.op = OP_FILL;
            ST_EMIT_FILL:   cmd.op = OP_EMIT_FILL;
            ST_FIX_BID:     cmd.op = OP_FIX_BID;
            ST_FIX_BID_CHK: cmd.op = OP_FIX_BID_CHK;
            ST_FIX_ASK:     cmd.op = OP_FIX_ASK;
            ST_FIX_ASK_CHK: cmd.op = OP_FIX_ASK_CHK;
            ST_REST_POP:    cmd.op = OP_REST_POP;
            ST_REST_WR:     cmd.op = OP_REST_WR;
            ST_REST_LINK:   cmd.op = OP_REST_LINK;
            ST_FIND:        cmd.op = OP_FIND;
            ST_FIND_CHK:    cmd.op = OP_FIND_CHK;
            ST_UNL_RD:      cmd.op = OP_UNL_RD;
            ST_UNL_CHK:     cmd.op = OP_UNL_CHK;
            ST_WALK_RD:     cmd.op = OP_WALK_RD;
            ST_WALK_CHK:    cmd.op = OP_WALK_CHK;
            ST_RELEASE:     cmd.op = OP_RELEASE;
            ST_FIN_ZERO:    cmd.op = OP_FIN_ZERO;
            ST_FIN_UNK:     cmd.op = OP_FIN_UNK;
            ST_FIN_FULL:    cmd.op = OP_FIN_FULL;
            ST_FIN_REST:    cmd.op = OP_FIN_REST;
            default:        cmd.op = OP_NOP;
        endcase
    end

endmodule

### hdl/lobm_dp.sv
// Order book datapath: slot pool, level FIFO heads and tails, free stack, best prices, result register.
module lobm_dp import lobm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    // Memories
    logic [ID_W-1:0]   id_mem   [ORDER_SLOTS];
    logic [QTY_W-1:0]  qty_mem  [ORDER_SLOTS];
    logic [PTR_W-1:0]  next_mem [ORDER_SLOTS];
    logic              sell_mem [ORDER_SLOTS];
    logic [LVL_W-1:0]  lvl_mem  [ORDER_SLOTS];
    logic [PTR_W-1:0]  head_mem [LI_DEPTH];
    logic [PTR_W-1:0]  tail_mem [LI_DEPTH];
    logic [SLOT_W-1:0] stk_mem  [ORDER_SLOTS];

    // Read data registers
    logic [ID_W-1:0]   id_rd_reg;
    logic [QTY_W-1:0]  qty_rd_reg;
    logic [PTR_W-1:0]  next_rd_reg;
    logic              sell_rd_reg;
    logic [LVL_W-1:0]  lvl_rd_reg;
    logic [PTR_W-1:0]  head_rd_reg;
    logic [PTR_W-1:0]  tail_rd_reg;
    logic [SLOT_W-1:0] pop_rd_reg;

    // Request and working registers
    action_t           req_act_reg;
    logic [ID_W-1:0]   req_id_reg;
    logic              req_side_reg;
    logic [LVL_W-1:0]  req_price_reg;
    logic [QTY_W-1:0]  req_qty_reg;
    logic [QTY_W-1:0]  rem_reg;
    logic              sell_reg;
    logic signed [BEST_W-1:0] px_reg;
    logic [SLOT_W-1:0] scan_reg;
    logic [SLOT_W-1:0] victim_reg;
    logic [LVL_W-1:0]  vlvl_reg;
    logic [PTR_W-1:0]  vnext_reg;
    logic [PTR_W-1:0]  prev_reg;
    logic [ID_W-1:0]   fill_id_reg;

    // Control state
    logic signed [BEST_W-1:0] bid_reg;
    logic signed [BEST_W-1:0] ask_reg;
    logic [CNT_W-1:0]  free_cnt_reg;
    logic [LI_W-1:0]   clr_reg;
    logic [ORDER_SLOTS-1:0] valid_reg;
    logic              m_tvalid_reg;

    // Result register payload
    logic [ID_W-1:0]   out_id_reg;
    logic              out_fv_reg;
    logic [QTY_W-1:0]  out_rem_reg;
    logic              out_rested_reg;
    logic [1:0]        out_status_reg;
    logic              out_last_reg;

    logic              in_fire;
    logic              out_free;
    logic [LI_W-1:0]   li_opp, li_own, li_vic;
    logic [QTY_W-1:0]  take_qty, new_qty;
    logic              fill_rel;
    logic [SLOT_W-1:0] head_slot;
    logic signed [BEST_W-1:0] price_s;
    logic              push_ok;

    // Port decode and shared terms
    assign s_tready  = (cmd.op == OP_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign li_opp    = {~sell_reg, px_reg[LVL_W-1:0]};
    assign li_own    = {sell_reg, req_price_reg};
    assign li_vic    = {sell_reg, vlvl_reg};
    assign head_slot = head_rd_reg[SLOT_W-1:0];
    assign take_qty  = (qty_rd_reg < rem_reg) ? qty_rd_reg : rem_reg;
    assign new_qty   = qty_rd_reg - take_qty;
    assign fill_rel  = (cmd.op == OP_FILL) && (new_qty == '0);
    assign price_s   = $signed({2'b00, req_price_reg});
    assign push_ok   = (free_cnt_reg != POOL_FULL_CNT);

    // Status to the controller
    always_comb begin
        stat.clr_done   = (clr_reg == CLR_LAST);
        stat.in_fire    = in_fire;
        stat.action     = req_act_reg;
        stat.rem_zero   = (rem_reg == '0);
        stat.pool_empty = (free_cnt_reg == '0);
        stat.lvl_go     = (rem_reg != '0) && (sell_reg ? (!px_reg[BEST_W-1] && px_reg >= price_s)
                                                      : (px_reg < ASK_NONE && px_reg <= price_s));
        stat.head_nil   = (head_rd_reg == NIL_PTR);
        stat.fill_done  = (new_qty == '0);
        stat.find_hit   = valid_reg[scan_reg] && (id_rd_reg == req_id_reg);
        stat.scan_last  = (scan_reg == SCAN_LAST);
        stat.unl_hit    = (head_rd_reg == {1'b0, victim_reg});
        stat.walk_end   = (next_rd_reg == {1'b0, victim_reg}) || (next_rd_reg == NIL_PTR);
        stat.bid_none   = bid_reg[BEST_W-1];
        stat.ask_none   = (ask_reg == ASK_NONE);
        stat.out_free   = out_free;
    end

    // Memory write ports and read addresses
    logic              hd_we, tl_we, stk_we, id_we, qty_we, nx_we, sl_we;
    logic [LI_W-1:0]   hd_wa, tl_wa, lvl_ra;
    logic [PTR_W-1:0]  hd_wd, tl_wd, nx_wd;
    logic [SLOT_W-1:0] stk_wa, stk_wd, qty_wa, nx_wa, sl_wa, slot_ra;
    logic [QTY_W-1:0]  qty_wd;
    logic              lvl_rd_en, slot_rd_en;

    always_comb begin
        hd_we = 1'b0; hd_wa = li_own; hd_wd = NIL_PTR;
        tl_we = 1'b0; tl_wa = li_own; tl_wd = NIL_PTR;
        stk_we = 1'b0; stk_wa = free_cnt_reg[SLOT_W-1:0]; stk_wd = victim_reg;
        id_we = 1'b0; sl_we = 1'b0; sl_wa = pop_rd_reg;
        qty_we = 1'b0; qty_wa = pop_rd_reg; qty_wd = rem_reg;
        nx_we = 1'b0; nx_wa = pop_rd_reg; nx_wd = NIL_PTR;
        lvl_rd_en = 1'b0; lvl_ra = li_own;
        slot_rd_en = 1'b0; slot_ra = scan_reg;
        unique case (cmd.op)
            OP_CLEAR: begin
                hd_we = 1'b1; hd_wa = clr_reg;
                tl_we = 1'b1; tl_wa = clr_reg;
                if (clr_reg < LI_W'(ORDER_SLOTS)) begin
                    stk_we = 1'b1;
                    stk_wa = clr_reg[SLOT_W-1:0];
                    stk_wd = clr_reg[SLOT_W-1:0];
                end
            end
            OP_HEAD_RD: begin
                lvl_rd_en = 1'b1; lvl_ra = li_opp;
            end
            OP_HEAD_CHK: begin
                slot_rd_en = 1'b1; slot_ra = head_slot;
            end
            OP_FILL: begin
                qty_we = 1'b1; qty_wa = head_slot; qty_wd = new_qty;
                if (fill_rel) begin
                    hd_we = 1'b1; hd_wa = li_opp; hd_wd = next_rd_reg;
                    tl_wa = li_opp;
                    tl_we = (tail_rd_reg == head_rd_reg);
                    stk_we = push_ok; stk_wd = head_slot;
                end
            end
            OP_FIX_BID: begin
                lvl_rd_en = 1'b1; lvl_ra = {1'b0, bid_reg[LVL_W-1:0]};
            end
            OP_FIX_ASK: begin
                lvl_rd_en = 1'b1; lvl_ra = {1'b1, ask_reg[LVL_W-1:0]};
            end
            OP_REST_POP: begin
                lvl_rd_en = 1'b1; lvl_ra = li_own;
            end
            OP_REST_WR: begin
                id_we = 1'b1; qty_we = 1'b1; nx_we = 1'b1; sl_we = 1'b1;
            end
            OP_REST_LINK: begin
                if (head_rd_reg == NIL_PTR) begin
                    hd_we = 1'b1; hd_wd = {1'b0, pop_rd_reg};
                end else begin
                    nx_we = 1'b1; nx_wa = tail_rd_reg[SLOT_W-1:0]; nx_wd = {1'b0, pop_rd_reg};
                end
                tl_we = 1'b1; tl_wd = {1'b0, pop_rd_reg};
            end
            OP_FIND: begin
                slot_rd_en = 1'b1; slot_ra = scan_reg;
            end
            OP_UNL_RD: begin
                lvl_rd_en = 1'b1; lvl_ra = li_vic;
            end
            OP_UNL_CHK: begin
                if (head_rd_reg == {1'b0, victim_reg}) begin
                    hd_we = 1'b1; hd_wa = li_vic; hd_wd = vnext_reg;
                    tl_wa = li_vic;
                    tl_we = (tail_rd_reg == {1'b0, victim_reg});
                end
            end
            OP_WALK_RD: begin
                slot_rd_en = 1'b1; slot_ra = prev_reg[SLOT_W-1:0];
            end
            OP_WALK_CHK: begin
                if (next_rd_reg == {1'b0, victim_reg}) begin
                    nx_we = 1'b1; nx_wa = prev_reg[SLOT_W-1:0]; nx_wd = vnext_reg;
                    tl_wa = li_vic; tl_wd = prev_reg;
                    tl_we = (tail_rd_reg == {1'b0, victim_reg});
                end
            end
            OP_RELEASE: begin
                stk_we = push_ok; stk_wd = victim_reg;
            end
            default: ;
        endcase
    end

    // Level memories
    always_ff @(posedge aclk) begin
        if (hd_we) head_mem[hd_wa] <= hd_wd;
        if (tl_we) tail_mem[tl_wa] <= tl_wd;
        if (lvl_rd_en) begin
            head_rd_reg <= head_mem[lvl_ra];
            tail_rd_reg <= tail_mem[lvl_ra];
        end else if (fill_rel) begin
            head_rd_reg <= next_rd_reg;
            if (tail_rd_reg == head_rd_reg) tail_rd_reg <= NIL_PTR;
        end
    end

    // Slot memories
    always_ff @(posedge aclk) begin
        if (id_we)  id_mem[pop_rd_reg] <= req_id_reg;
        if (qty_we) qty_mem[qty_wa] <= qty_wd;
        if (nx_we)  next_mem[nx_wa] <= nx_wd;
        if (sl_we) begin
            sell_mem[sl_wa] <= sell_reg;
            lvl_mem[sl_wa]  <= req_price_reg;
        end
        if (slot_rd_en) begin
            id_rd_reg   <= id_mem[slot_ra];
            qty_rd_reg  <= qty_mem[slot_ra];
            next_rd_reg <= next_mem[slot_ra];
            sell_rd_reg <= sell_mem[slot_ra];
            lvl_rd_reg  <= lvl_mem[slot_ra];
        end
    end

    // Free slot stack
    always_ff @(posedge aclk) begin
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
        if (cmd.op == OP_REST_POP) pop_rd_reg <= stk_mem[free_cnt_reg[SLOT_W-1:0] - SLOT_W'(1)];
    end

    // Control state: best prices, pool count, clearing pass, valid bits, result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bid_reg      <= BID_NONE;
            ask_reg      <= ASK_NONE;
            free_cnt_reg <= POOL_FULL_CNT;
            clr_reg      <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (cmd.op)
                OP_CLEAR:       clr_reg <= clr_reg + LI_W'(1);
                OP_FILL: begin
                    if (fill_rel) begin
                        valid_reg[head_slot] <= 1'b0;
                        if (push_ok) free_cnt_reg <= free_cnt_reg + CNT_W'(1);
                    end
                end
                OP_FIX_BID_CHK: if (head_rd_reg == NIL_PTR) bid_reg <= bid_reg - BEST_W'(1);
                OP_FIX_ASK_CHK: if (head_rd_reg == NIL_PTR) ask_reg <= ask_reg + BEST_W'(1);
                OP_REST_POP:    free_cnt_reg <= free_cnt_reg - CNT_W'(1);
                OP_REST_WR:     valid_reg[pop_rd_reg] <= 1'b1;
                OP_REST_LINK: begin
                    if (sell_reg) begin
                        if (price_s < ask_reg) ask_reg <= price_s;
                    end else begin
                        if (price_s > bid_reg) bid_reg <= price_s;
                    end
                end
                OP_RELEASE: begin
                    valid_reg[victim_reg] <= 1'b0;
                    if (push_ok) free_cnt_reg <= free_cnt_reg + CNT_W'(1);
                end
                default: ;
            endcase
            if ((cmd.op == OP_EMIT_FILL || cmd.op == OP_FIN_ZERO || cmd.op == OP_FIN_UNK ||
                 cmd.op == OP_FIN_FULL || cmd.op == OP_FIN_REST) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request capture and working registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            req_act_reg   <= action_t'(s_tuser);
            req_id_reg    <= s_tdata[ID_W-1:0];
            req_side_reg  <= s_tdata[ID_W];
            req_price_reg <= s_tdata[ID_W+LVL_W:ID_W+1];
            req_qty_reg   <= s_tdata[ID_W+LVL_W+QTY_W:ID_W+LVL_W+1];
        end
        unique case (cmd.op)
            OP_DECODE: begin
                rem_reg  <= req_qty_reg;
                sell_reg <= req_side_reg;
                scan_reg <= '0;
            end
            OP_ADD_START: px_reg <= sell_reg ? bid_reg : ask_reg;
            OP_LVL_NEXT:  px_reg <= sell_reg ? px_reg - BEST_W'(1) : px_reg + BEST_W'(1);
            OP_FILL: begin
                rem_reg     <= rem_reg - take_qty;
                fill_id_reg <= id_rd_reg;
            end
            OP_FIND_CHK: begin
                if (valid_reg[scan_reg] && id_rd_reg == req_id_reg) begin
                    rem_reg    <= qty_rd_reg;
                    sell_reg   <= sell_rd_reg;
                    victim_reg <= scan_reg;
                    vlvl_reg   <= lvl_rd_reg;
                    vnext_reg  <= next_rd_reg;
                end else begin
                    scan_reg <= scan_reg + SLOT_W'(1);
                end
            end
            OP_UNL_CHK:  prev_reg <= head_rd_reg;
            OP_WALK_CHK: prev_reg <= next_rd_reg;
            default: ;
        endcase
    end

    // Result register load
    always_ff @(posedge aclk) begin
        if (out_free) begin
            unique case (cmd.op)
                OP_EMIT_FILL: begin
                    out_id_reg <= fill_id_reg; out_fv_reg <= 1'b1; out_rem_reg <= rem_reg;
                    out_rested_reg <= 1'b0; out_status_reg <= RES_OK; out_last_reg <= 1'b0;
                end
                OP_FIN_ZERO, OP_FIN_UNK: begin
                    out_id_reg <= '0; out_fv_reg <= 1'b0; out_rem_reg <= '0;
                    out_rested_reg <= 1'b0; out_last_reg <= 1'b1;
                    out_status_reg <= (cmd.op == OP_FIN_UNK) ? RES_UNKNOWN : RES_OK;
                end
                OP_FIN_FULL, OP_FIN_REST: begin
                    out_id_reg <= '0; out_fv_reg <= 1'b0; out_rem_reg <= rem_reg;
                    out_last_reg <= 1'b1;
                    out_rested_reg <= (cmd.op == OP_FIN_REST);
                    out_status_reg <= (cmd.op == OP_FIN_FULL) ? RES_POOL_FULL : RES_OK;
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_rested_reg, out_rem_reg, out_id_reg};
    assign m_tuser  = out_fv_reg;
    assign m_tlast  = out_last_reg;

    // Book is never crossed between requests
    a_not_crossed: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_IDLE) |-> (bid_reg < ask_reg))
        else $error("best bid not below best ask while idle");

    // Resting orders plus free slots never exceed the pool
    a_pool_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(valid_reg) + 32'(free_cnt_reg)) <= ORDER_SLOTS)
        else $error("slot accounting overflow");

    // A fill only runs against a live head with quantity left to match
    a_fill_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FILL) |-> (head_rd_reg != NIL_PTR && rem_reg != '0))
        else $error("fill without resting head or remaining quantity");

    // A pop only happens with a free slot on the stack
    a_pop_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_REST_POP) |-> (free_cnt_reg != '0))
        else $error("pop from empty free stack");

endmodule

### hdl/limit_order_book_matcher.sv
// Top level of the price-time-priority limit order book matcher.
// An add walks the opposite side level by level from its best price, filling resting orders oldest
// first, then moves the best prices past emptied levels and rests any remainder; output stalls
// hold it. Cancel and modify scan the pool for the id (up to 64 slots) and walk the level FIFO
// to unlink the order; one request in flight at a time.
// Reset: a clearing pass empties the level FIFOs and loads the free stack; no input before.
module limit_order_book_matcher import lobm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // id[30:0], side[31], level[41:32], quantity[57:42]
    input  logic [1:0]           s_tuser,  // action[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // filled_order_id[30:0], incoming_remaining[46:31],
                                           // incoming_rested[47], status[49:48]
    output logic                 m_tuser,  // filled_valid
    output logic                 m_tlast   // last
);

    cmd_t  cmd;
    stat_t stat;

    lobm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    lobm_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### tb/tb_limit_order_book_matcher.sv
// Self-checking testbench for the price-time-priority limit order book matcher.
module tb_limit_order_book_matcher;
    import lobm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int NIL = ORDER_SLOTS;

    typedef struct {
        logic [ID_W-1:0]  filled_id;
        logic             filled_valid;
        logic [QTY_W-1:0] remaining;
        logic             rested;
        logic [1:0]       status;
        logic             last;
    } fill_report_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // Book mirror
    logic [ID_W-1:0]  bk_id     [ORDER_SLOTS];
    logic [QTY_W-1:0] bk_qty    [ORDER_SLOTS];
    int               bk_next   [ORDER_SLOTS];
    bit               bk_valid  [ORDER_SLOTS];
    bit               bk_sell   [ORDER_SLOTS];
    int               bk_level  [ORDER_SLOTS];
    int               lvl_head  [LI_DEPTH];
    int               lvl_tail  [LI_DEPTH];
    int               free_stack[ORDER_SLOTS];
    int               free_cnt;
    int               best_bid;
    int               best_ask;

    fill_report_t pending_reports[$];

    int  error_count;
    int  requests_sent;
    int  reports_seen;
    int  fills_seen;
    int  pool_full_seen;
    int  unknown_seen;
    int  idle_cycles;
    int  hold_cycles;
    bit  quiet;

    limit_order_book_matcher uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // Clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Book mirror helpers
    function automatic int book_index(bit sell, int level);
        return (sell ? PRICE_LEVELS : 0) + level;
    endfunction

    task automatic book_clear();
        for (int i = 0; i < ORDER_SLOTS; i++) begin
            bk_valid[i]   = 1'b0;
            free_stack[i] = i;
        end
        for (int i = 0; i < LI_DEPTH; i++) begin
            lvl_head[i] = NIL;
            lvl_tail[i] = NIL;
        end
        free_cnt = ORDER_SLOTS;
        best_bid = -1;
        best_ask = PRICE_LEVELS;
    endtask

    task automatic push_report(logic [ID_W-1:0] id, bit fv, int rem, bit rested,
                               logic [1:0] status, bit last);
        fill_report_t r;
        r.filled_id    = id;
        r.filled_valid = fv;
        r.remaining    = rem[QTY_W-1:0];
        r.rested       = rested;
        r.status       = status;
        r.last         = last;
        pending_reports.insert(pending_reports.size(), r);
    endtask

    task automatic free_slot(int s);
        bk_valid[s] = 1'b0;
        if (free_cnt < ORDER_SLOTS) begin
            free_stack[free_cnt] = s;
            free_cnt++;
        end
    endtask

    // Walk the best prices outward past empty levels
    task automatic refresh_best();
        while (best_bid >= 0 && lvl_head[book_index(0, best_bid)] == NIL)
            best_bid--;
        while (best_ask < PRICE_LEVELS && lvl_head[book_index(1, best_ask)] == NIL)
            best_ask++;
    endtask

    // Fill oldest-first at one level; returns the residual
    task automatic sweep_level(int li, inout int rem);
        int h;
        int take;
        while (rem > 0 && lvl_head[li] < ORDER_SLOTS) begin
            h    = lvl_head[li];
            take = (bk_qty[h] < rem) ? int'(bk_qty[h]) : rem;
            bk_qty[h] = QTY_W'(int'(bk_qty[h]) - take);
            rem = rem - take;
            if (bk_qty[h] == 0) begin
                lvl_head[li] = bk_next[h];
                if (lvl_tail[li] == h) lvl_tail[li] = NIL;
                free_slot(h);
                push_report(bk_id[h], 1'b1, rem, 1'b0, RES_OK, 1'b0);
            end
        end
    endtask

    task automatic match_and_rest(logic [ID_W-1:0] id, bit sell, int price, int qty);
        int rem;
        int s;
        int li;
        rem = qty;
        if (qty == 0) begin
            push_report('0, 0, 0, 0, RES_OK, 1);
            return;
        end
        if (free_cnt == 0) begin
            push_report('0, 0, qty, 0, RES_POOL_FULL, 1);
            return;
        end
        if (sell) begin
            for (int px = best_bid; px >= 0 && px >= price && rem > 0; px--)
                sweep_level(book_index(0, px), rem);
        end else begin
            for (int px = best_ask; px < PRICE_LEVELS && px <= price && rem > 0; px++)
                sweep_level(book_index(1, px), rem);
        end
        refresh_best();
        if (rem == 0) begin
            push_report('0, 0, 0, 0, RES_OK, 1);
            return;
        end
        free_cnt--;
        s = free_stack[free_cnt];
        bk_id[s]    = id;
        bk_qty[s]   = rem[QTY_W-1:0];
        bk_next[s]  = NIL;
        bk_valid[s] = 1'b1;
        bk_sell[s]  = sell;
        bk_level[s] = price;
        li = book_index(sell, price);
        if (lvl_head[li] == NIL) lvl_head[li] = s;
        else bk_next[lvl_tail[li]] = s;
        lvl_tail[li] = s;
        if (sell && price < best_ask) best_ask = price;
        if (!sell && price > best_bid) best_bid = price;
        push_report('0, 0, rem, 1, RES_OK, 1);
    endtask

    task automatic unlink_order(int s);
        int li;
        int prev;
        int cur;
        li = book_index(bk_sell[s], bk_level[s]);
        if (lvl_head[li] == s) begin
            lvl_head[li] = bk_next[s];
            if (lvl_tail[li] == s) lvl_tail[li] = NIL;
            return;
        end
        prev = lvl_head[li];
        for (int k = 0; prev < ORDER_SLOTS && k < ORDER_SLOTS; k++) begin
            cur = bk_next[prev];
            if (cur == s) begin
                bk_next[prev] = bk_next[s];
                if (lvl_tail[li] == s) lvl_tail[li] = prev;
                return;
            end
            prev = cur;
        end
    endtask

    // Expected results of one accepted request
    task automatic book_predict(action_t act, logic [ID_W-1:0] id, bit side, int price, int qty);
        int s;
        bit old_sell;
        int old_qty;
        if (act == ACT_ADD) begin
            match_and_rest(id, side, price, qty);
        end else if (act == ACT_CANCEL || act == ACT_MODIFY) begin
            s = NIL;
            for (int i = ORDER_SLOTS - 1; i >= 0; i--)
                if (bk_valid[i] && bk_id[i] == id) s = i;
            if (s == NIL) begin
                push_report('0, 0, 0, 0, RES_UNKNOWN, 1);
            end else begin
                old_sell = bk_sell[s];
                old_qty  = bk_qty[s];
                unlink_order(s);
                free_slot(s);
                refresh_best();
                if (act == ACT_CANCEL) push_report('0, 0, 0, 0, RES_OK, 1);
                else match_and_rest(id, old_sell, price, old_qty);
            end
        end else begin
            push_report('0, 0, 0, 0, RES_OK, 1);
        end
    endtask

    // Send one request; predict once it is accepted
    task automatic send_request(action_t act, logic [ID_W-1:0] id, bit side, int price,
                                int qty);
        if (!quiet && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, qty[QTY_W-1:0], price[LVL_W-1:0], side, id};
        do @(posedge aclk); while (!s_tready);
        book_predict(act, id, side, price, qty);
        requests_sent++;
    endtask

    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    // Random content generators
    function automatic logic [ID_W-1:0] any_id();
        return ID_W'($urandom());
    endfunction

    function automatic logic [ID_W-1:0] resting_id();
        int picks[$];
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (bk_valid[i]) picks.insert(picks.size(), i);
        if (picks.size() == 0) return any_id();
        return bk_id[picks[$urandom_range(picks.size() - 1)]];
    endfunction

    function automatic int any_price();
        if ($urandom_range(9) == 0) return $urandom_range(PRICE_LEVELS - 1);
        return $urandom_range(490, 530);
    endfunction

    function automatic int any_qty();
        case ($urandom_range(19))
            0: return 0;
            1: return $urandom_range(65535);
            2: return 65535;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    // Result check
    always @(posedge aclk) begin
        fill_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            reports_seen++;
            if (m_tuser) fills_seen++;
            if (m_tdata[49:48] == RES_POOL_FULL) pool_full_seen++;
            if (m_tdata[49:48] == RES_UNKNOWN) unknown_seen++;
            if (pending_reports.size() == 0) begin
                $error("result with nothing expected: tdata=%h", m_tdata);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_tdata[30:0] !== want.filled_id) begin
                    $error("filled_order_id: expected %h, got %h", want.filled_id, m_tdata[30:0]);
                    error_count++;
                end
                if (m_tuser !== want.filled_valid) begin
                    $error("filled_valid: expected %0d, got %0d", want.filled_valid, m_tuser);
                    error_count++;
                end
                if (m_tdata[46:31] !== want.remaining) begin
                    $error("incoming_remaining: expected %0d, got %0d", want.remaining,
                           m_tdata[46:31]);
                    error_count++;
                end
                if (m_tdata[47] !== want.rested) begin
                    $error("incoming_rested: expected %0d, got %0d", want.rested, m_tdata[47]);
                    error_count++;
                end
                if (m_tdata[49:48] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[49:48]);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Receiver backpressure, with an optional long hold-off
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= quiet || ($urandom_range(99) >= 14);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding", pending_reports.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Directed: extremes, every action and the corner cases
    task automatic test_directed();
        send_request(ACT_ADD, 31'd1, 1'b0, 0, 1);                // lowest bid
        send_request(ACT_ADD, 31'h7FFF_FFFF, 1'b1, 1023, 65535); // highest ask
        send_request(ACT_ADD, 31'd3, 1'b0, 1023, 65535);         // sweeps the full ask
        send_request(ACT_ADD, 31'd4, 1'b1, 0, 5);                // hits the bid, rests
        send_request(ACT_ADD, 31'd5, 1'b0, 10, 0);               // zero quantity
        send_request(ACT_CANCEL, 31'h1234_5678, 1'b0, 0, 0);     // unknown cancel
        send_request(ACT_MODIFY, 31'h7654_3210, 1'b1, 5, 9);     // unknown modify
        send_request(ACT_NONE, 31'h7FFF_FFFF, 1'b1, 1023, 65535);
        // duplicate ids: cancel takes the lowest slot
        send_request(ACT_ADD, 31'd20, 1'b0, 100, 7);
        send_request(ACT_ADD, 31'd20, 1'b0, 101, 8);
        send_request(ACT_ADD, 31'd20, 1'b0, 100, 9);
        send_request(ACT_CANCEL, 31'd20, 1'b0, 0, 0);
        // middle-of-FIFO removal
        send_request(ACT_ADD, 31'd30, 1'b1, 700, 3);
        send_request(ACT_ADD, 31'd31, 1'b1, 700, 4);
        send_request(ACT_ADD, 31'd32, 1'b1, 700, 5);
        send_request(ACT_CANCEL, 31'd31, 1'b0, 0, 0);
        // modify that crosses the book
        send_request(ACT_MODIFY, 31'd20, 1'b1, 700, 0);
        send_request(ACT_ADD, 31'd33, 1'b0, 800, 100);
        send_request(ACT_MODIFY, 31'd4, 1'b0, 200, 0);
        drain_reports();
    endtask

    // Long receiver stall while the pool fills, then a sweep of many fills
    task automatic test_pool_full();
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (bk_valid[i]) send_request(ACT_CANCEL, bk_id[i], 1'b0, 0, 0);
        drain_reports();
        hold_cycles = 400;
        for (int i = 0; i < ORDER_SLOTS + 2; i++)
            send_request(ACT_ADD, any_id(), 1'b0, $urandom_range(0, 40), $urandom_range(1, 9));
        // free one slot so the sweep is admitted
        send_request(ACT_CANCEL, resting_id(), 1'b0, 0, 0);
        send_request(ACT_ADD, any_id(), 1'b1, 0, 65535);
        drain_reports();
    endtask

    // Random mix, mostly well-formed requests against live orders
    task automatic test_random(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            quiet = (n >= count / 3 && n < count / 2);
            pick = $urandom_range(99);
            if (pick < 55)
                send_request(ACT_ADD, ($urandom_range(9) == 0) ? resting_id() : any_id(),
                             $urandom_range(1), any_price(), any_qty());
            else if (pick < 75)
                send_request(ACT_CANCEL, ($urandom_range(4) == 0) ? any_id() : resting_id(),
                             $urandom_range(1), $urandom_range(1023), $urandom_range(65535));
            else if (pick < 95)
                send_request(ACT_MODIFY, ($urandom_range(4) == 0) ? any_id() : resting_id(),
                             $urandom_range(1), any_price(), $urandom_range(65535));
            else
                send_request(ACT_NONE, any_id(), $urandom_range(1), $urandom_range(1023),
                             $urandom_range(65535));
            if (n == count / 2) drain_reports();
        end
        quiet = 1'b0;
    endtask

    initial begin
        error_count    = 0;
        requests_sent  = 0;
        reports_seen   = 0;
        fills_seen     = 0;
        pool_full_seen = 0;
        unknown_seen   = 0;
        idle_cycles    = 0;
        hold_cycles    = 0;
        quiet          = 1'b0;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ACT_ADD;
        m_tready       = 1'b0;
        book_clear();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_pool_full();
        test_random(200);

        drain_reports();
        repeat (300) @(posedge aclk);
        $display("Covered %0d requests, %0d results with %0d fills,", requests_sent,
                 reports_seen, fills_seen);
        $display("%0d pool-full and %0d unknown-id replies, a long output stall and a drain.",
                 pool_full_seen, unknown_seen);
        if (error_count == 0 && pending_reports.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/lobm_pkg.sv
hdl/lobm_ctrl.sv
hdl/lobm_dp.sv
hdl/limit_order_book_matcher.sv
tb/tb_limit_order_book_matcher.sv
